FILE: hdl/civ_pkg.sv
// ----------------------------------------------------------------------------
// civ_pkg
// Shared widths, register map, status codes and helpers for the cylindrical
// inlet velocity block.
// ----------------------------------------------------------------------------
package civ_pkg;

	localparam int ADDR_W = 6;

	localparam logic [2:0] REG_CENTRE = 3'd0;
	localparam logic [2:0] REG_AXIS   = 3'd1;
	localparam logic [2:0] REG_AXIAL  = 3'd2;
	localparam logic [2:0] REG_RADIAL = 3'd3;
	localparam logic [2:0] REG_SPIN   = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_ON_AXIS   = 2'd1;
	localparam logic [1:0] STAT_ZERO_AXIS = 2'd2;

	localparam logic [47:0] AXIS_RESET = 48'h0100_0000_0000;

	// pi/30 with 20 fraction bits
	localparam logic signed [17:0] PI_OVER_30_Q20 = 18'sd109807;

	// quotient bits of each long division, root steps of the per-word root
	localparam int NA = 18;
	localparam int NC = 18;
	localparam int NR = 17;
	localparam int NX = 17;
	localparam int NQ = 27;

	// datapath widths
	localparam int NAW = 50;
	localparam int CNW = 45;
	localparam int RNW = 44;
	localparam int XW  = 54;
	localparam int DW  = 40;

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		logic signed [23:0] r;
		if (v > 34'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -34'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/cylindrical_inlet_velocity.sv
// ----------------------------------------------------------------------------
// cylindrical_inlet_velocity
// Pipelined inlet velocity of a swirling cylindrical inlet, one face point
// per word.
// ----------------------------------------------------------------------------
// Takes one face-centre point per cycle while point_ready is high and returns
// swirl + axial + radial velocity, saturated to Q15.8. The pipeline depth is
// set by the bit-per-stage dividers (axial projection, swirl, radial) and the
// bit-per-stage square root of |d|. After reset and after any register write
// the block recomputes the axis norm, its root, the axial term and the spin
// factor with one serial sequencer; point_ready stays low for that time.
// Status 1 marks a point on the axis (radial term zero), status 2 a zero axis
// (all outputs zero).
module cylindrical_inlet_velocity import civ_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [63:0]              pwdata,
	output logic [63:0]              prdata,
	output logic                     pready,
	input  logic                     point_valid,
	output logic                     point_ready,
	input  logic signed [15:0]       point_x,
	input  logic signed [15:0]       point_y,
	input  logic signed [15:0]       point_z,
	output logic                     vel_valid,
	input  logic                     vel_ready,
	output logic signed [23:0]       vel_x,
	output logic signed [23:0]       vel_y,
	output logic signed [23:0]       vel_z,
	output logic [1:0]               status
);

	// stage numbers
	localparam int P_R  = 1;
	localparam int P_P  = P_R + 1;
	localparam int P_AR = P_P + 1;
	localparam int P_T  = P_AR + 1;
	localparam int P_AN = P_T + 1;
	localparam int P_A0 = P_AN + 1;
	localparam int P_AE = P_A0 + NA - 1;
	localparam int P_D  = P_AE + 1;
	localparam int P_X1 = P_D + 1;
	localparam int P_X2 = P_X1 + 1;
	localparam int P_QI = P_X2 + 1;
	localparam int P_Q0 = P_QI + 1;
	localparam int P_QE = P_Q0 + NQ - 1;
	localparam int P_RP = P_QE + 1;
	localparam int P_RI = P_RP + 1;
	localparam int P_R0 = P_RI + 1;
	localparam int P_L  = P_R0 + NR - 1;

	localparam logic [2:0] SEQ_IDLE  = 3'd0;
	localparam logic [2:0] SEQ_NORM  = 3'd1;
	localparam logic [2:0] SEQ_ROOT  = 3'd2;
	localparam logic [2:0] SEQ_DINIT = 3'd3;
	localparam logic [2:0] SEQ_DSTEP = 3'd4;

	// configuration
	logic [47:0]        centre_q;
	logic [47:0]        axis_q;
	logic signed [15:0] axial_q;
	logic signed [15:0] radial_q;
	logic signed [15:0] spin_q;
	logic               wr_en;

	logic signed [15:0] ax_a [3];
	logic signed [15:0] cen [3];
	logic signed [15:0] pt [3];
	logic               zero_axis;

	// precompute sequencer
	logic [2:0]         seq_q;
	logic [4:0]         cnt_q;
	logic [1:0]         lane_q;
	logic [31:0]        n_q;
	logic [47:0]        rx_q;
	logic [47:0]        rres_q;
	logic [47:0]        rbit_q;
	logic [23:0]        s_q;
	logic [DW-1:0]      dnum_q;
	logic [DW-1:0]      dden_q;
	logic [NX-1:0]      dq_q;
	logic               dneg_q;
	logic signed [32:0] w_q;
	logic signed [NX:0] axt_q [3];
	logic               busy;

	logic [1:0]         nidx;
	logic signed [31:0] nsq;
	logic [31:0]        n_sum;
	logic [47:0]        rtry;
	logic               rge;
	logic [47:0]        rres_nx;
	logic signed [31:0] dprod;
	logic [31:0]        dmag;
	logic               dge;
	logic [NX-1:0]      dq_nx;

	// pipeline
	logic               en;
	logic [P_L:1]       vld_s;
	logic signed [16:0] r_s [P_R:P_AE][3];
	logic signed [32:0] pr_s [3];
	logic signed [34:0] ar_s;
	logic signed [49:0] t_s [3];
	logic [NAW-1:0]     na_s [P_AN:P_AE][3];
	logic [NA-1:0]      qa_s [P_AN:P_AE][3];
	logic               nga_s [P_AN:P_AE][3];
	logic signed [18:0] d_s [P_D:P_QE][3];
	logic [36:0]        sqd_s [3];
	logic signed [34:0] cpa_s [3];
	logic signed [34:0] cpb_s [3];
	logic [37:0]        m_s;
	logic signed [35:0] cr_s [3];
	logic [XW-1:0]      rx_s [P_QI:P_QE];
	logic [XW-1:0]      rr_s [P_QI:P_QE];
	logic [CNW-1:0]     cn_s [P_QI:P_QE][3];
	logic [NC-1:0]      cq_s [P_QI:P_QE][3];
	logic               cg_s [P_QI:P_QE][3];
	logic               mz_s [P_QI:P_L];
	logic signed [51:0] wc_s [3];
	logic signed [34:0] rp_s [3];
	logic [26:0]        qd_s [P_RP:P_L];
	logic signed [32:0] sw_s [P_RI:P_L][3];
	logic [RNW-1:0]     rn_s [P_RI:P_L][3];
	logic [NR-1:0]      rq_s [P_RI:P_L][3];
	logic               rg_s [P_RI:P_L][3];

	// output side
	logic signed [23:0] res_v [3];
	logic [1:0]         res_st;
	logic               pipe_out;
	logic               skid_v_q;
	logic signed [23:0] skid_v_d_q [3];
	logic [1:0]         skid_st_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_a[i] = axis_q[16*i +: 16];
			cen[i]  = centre_q[16*i +: 16];
		end
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
	end

	assign zero_axis = (axis_q == 48'h0);

	// ---------------- register port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= 48'h0;
			axis_q   <= AXIS_RESET;
			axial_q  <= 16'sh0;
			radial_q <= 16'sh0;
			spin_q   <= 16'sh0;
		end else if (wr_en) begin
			case (paddr[5:3])
				REG_CENTRE: centre_q <= pwdata[47:0];
				REG_AXIS:   axis_q   <= pwdata[47:0];
				REG_AXIAL:  axial_q  <= pwdata[15:0];
				REG_RADIAL: radial_q <= pwdata[15:0];
				REG_SPIN:   spin_q   <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_CENTRE: prdata = {16'h0, centre_q};
			REG_AXIS:   prdata = {16'h0, axis_q};
			REG_AXIAL:  prdata = {48'h0, axial_q};
			REG_RADIAL: prdata = {48'h0, radial_q};
			REG_SPIN:   prdata = {48'h0, spin_q};
			default:    prdata = 64'h0;
		endcase
	end

	// ---------------- axis precompute ----------------
	assign busy = (seq_q != SEQ_IDLE);

	always_comb begin
		nidx    = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
		nsq     = 32'(ax_a[nidx]) * 32'(ax_a[nidx]);
		n_sum   = n_q + unsigned'(nsq);
		rtry    = rres_q + rbit_q;
		rge     = (rx_q >= rtry);
		rres_nx = rge ? ((rres_q >> 1) + rbit_q) : (rres_q >> 1);
		dprod   = 32'(axial_q) * 32'(ax_a[lane_q]);
		dmag    = dprod[31] ? unsigned'(-dprod) : unsigned'(dprod);
		dge     = (dnum_q >= dden_q);
		dq_nx   = {dq_q[NX-2:0], dge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_NORM;
			cnt_q  <= 5'd0;
			lane_q <= 2'd0;
			n_q    <= 32'h0;
		end else if (wr_en) begin
			seq_q  <= SEQ_NORM;
			cnt_q  <= 5'd0;
			lane_q <= 2'd0;
			n_q    <= 32'h0;
		end else begin
			case (seq_q)
				SEQ_IDLE: ;
				SEQ_NORM: begin
					n_q <= n_sum;
					if (cnt_q == 5'd2) begin
						cnt_q <= 5'd0;
						seq_q <= (n_sum == 32'h0) ? SEQ_IDLE : SEQ_ROOT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				SEQ_ROOT: begin
					if (rbit_q[0]) seq_q <= SEQ_DINIT;
				end
				SEQ_DINIT: begin
					seq_q <= SEQ_DSTEP;
					cnt_q <= 5'd0;
				end
				SEQ_DSTEP: begin
					if (cnt_q == 5'(NX - 1)) begin
						cnt_q <= 5'd0;
						if (lane_q == 2'd2) begin
							seq_q <= SEQ_IDLE;
						end else begin
							lane_q <= lane_q + 2'd1;
							seq_q  <= SEQ_DINIT;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: seq_q <= SEQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_NORM && cnt_q == 5'd0) begin
			w_q <= 33'(spin_q * PI_OVER_30_Q20);
		end
		if (seq_q == SEQ_NORM && cnt_q == 5'd2) begin
			rx_q   <= {n_sum, 16'h0};
			rres_q <= 48'h0;
			rbit_q <= 48'h1 << 46;
		end
		if (seq_q == SEQ_ROOT) begin
			if (rge) rx_q <= rx_q - rtry;
			rres_q <= rres_nx;
			rbit_q <= rbit_q >> 2;
			if (rbit_q[0]) s_q <= rres_nx[23:0];
		end
		if (seq_q == SEQ_DINIT) begin
			dnum_q <= (DW'(dmag) << 8) + DW'(s_q >> 1);
			dneg_q <= dprod[31];
			dden_q <= DW'(s_q) << (NX - 1);
			dq_q   <= '0;
		end
		if (seq_q == SEQ_DSTEP) begin
			if (dge) dnum_q <= dnum_q - dden_q;
			dden_q <= dden_q >> 1;
			dq_q   <= dq_nx;
			if (cnt_q == 5'(NX - 1)) begin
				axt_q[lane_q] <= dneg_q ? -$signed({1'b0, dq_nx}) : $signed({1'b0, dq_nx});
			end
		end
	end

	// ---------------- pipeline ----------------
	assign en          = ~skid_v_q;
	assign point_ready = en & ~busy & ~wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[P_L-1:1], point_valid & point_ready};
		end
	end

	// offset, projection onto the axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s[P_R][i] <= 17'(pt[i]) - 17'(cen[i]);
				for (int k = P_P; k <= P_AE; k++) r_s[k][i] <= r_s[k-1][i];
				pr_s[i] <= 33'(ax_a[i]) * 33'(r_s[P_R][i]);
				t_s[i]  <= 50'(ar_s) * 50'(ax_a[i]);
				na_s[P_AN][i]  <= (t_s[i][49] ? NAW'(-t_s[i]) : NAW'(t_s[i]))
					+ NAW'(n_q >> 1);
				nga_s[P_AN][i] <= t_s[i][49];
				qa_s[P_AN][i]  <= '0;
			end
			ar_s <= 35'(pr_s[0]) + 35'(pr_s[1]) + 35'(pr_s[2]);
		end
	end

	// divide by |a|^2, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NA; k++) begin
				for (int i = 0; i < 3; i++) begin
					if (na_s[P_A0+k-1][i] >= (NAW'(n_q) << (NA - 1 - k))) begin
						na_s[P_A0+k][i] <= na_s[P_A0+k-1][i] - (NAW'(n_q) << (NA - 1 - k));
						qa_s[P_A0+k][i] <= {qa_s[P_A0+k-1][i][NA-2:0], 1'b1};
					end else begin
						na_s[P_A0+k][i] <= na_s[P_A0+k-1][i];
						qa_s[P_A0+k][i] <= {qa_s[P_A0+k-1][i][NA-2:0], 1'b0};
					end
					nga_s[P_A0+k][i] <= nga_s[P_A0+k-1][i];
				end
			end
		end
	end

	// radial offset, cross product and |d|^2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s[P_D][i] <= 19'(20'(r_s[P_AE][i]) - (nga_s[P_AE][i]
					? -$signed({2'b0, qa_s[P_AE][i]}) : $signed({2'b0, qa_s[P_AE][i]})));
				for (int k = P_D + 1; k <= P_QE; k++) d_s[k][i] <= d_s[k-1][i];
				sqd_s[i] <= 37'(unsigned'(38'(d_s[P_D][i]) * 38'(d_s[P_D][i])));
				cr_s[i]  <= 36'(cpa_s[i]) - 36'(cpb_s[i]);
			end
			cpa_s[0] <= 35'(ax_a[1]) * 35'(d_s[P_D][2]);
			cpb_s[0] <= 35'(ax_a[2]) * 35'(d_s[P_D][1]);
			cpa_s[1] <= 35'(ax_a[2]) * 35'(d_s[P_D][0]);
			cpb_s[1] <= 35'(ax_a[0]) * 35'(d_s[P_D][2]);
			cpa_s[2] <= 35'(ax_a[0]) * 35'(d_s[P_D][1]);
			cpb_s[2] <= 35'(ax_a[1]) * 35'(d_s[P_D][0]);
			m_s <= 38'(sqd_s[0]) + 38'(sqd_s[1]) + 38'(sqd_s[2]);
		end
	end

	// root of |d|^2 and swirl divide by |a|, side by side
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[P_QI] <= {m_s, 16'h0};
			rr_s[P_QI] <= '0;
			mz_s[P_QI] <= (m_s == 38'h0);
			for (int i = 0; i < 3; i++) begin
				cn_s[P_QI][i] <= (cr_s[i][35] ? CNW'(-cr_s[i]) << 8 : CNW'(cr_s[i]) << 8)
					+ CNW'(s_q >> 1);
				cg_s[P_QI][i] <= cr_s[i][35];
				cq_s[P_QI][i] <= '0;
			end
			for (int k = 0; k < NQ; k++) begin
				if (rx_s[P_Q0+k-1] >= rr_s[P_Q0+k-1] + (XW'(1) << (2 * (NQ - 1 - k)))) begin
					rx_s[P_Q0+k] <= rx_s[P_Q0+k-1]
						- (rr_s[P_Q0+k-1] + (XW'(1) << (2 * (NQ - 1 - k))));
					rr_s[P_Q0+k] <= (rr_s[P_Q0+k-1] >> 1) + (XW'(1) << (2 * (NQ - 1 - k)));
				end else begin
					rx_s[P_Q0+k] <= rx_s[P_Q0+k-1];
					rr_s[P_Q0+k] <= rr_s[P_Q0+k-1] >> 1;
				end
				for (int i = 0; i < 3; i++) begin
					cg_s[P_Q0+k][i] <= cg_s[P_Q0+k-1][i];
					if (k < NC && cn_s[P_Q0+k-1][i] >= (CNW'(s_q) << (NC - 1 - k))) begin
						cn_s[P_Q0+k][i] <= cn_s[P_Q0+k-1][i] - (CNW'(s_q) << (NC - 1 - k));
						cq_s[P_Q0+k][i] <= {cq_s[P_Q0+k-1][i][NC-2:0], 1'b1};
					end else if (k < NC) begin
						cn_s[P_Q0+k][i] <= cn_s[P_Q0+k-1][i];
						cq_s[P_Q0+k][i] <= {cq_s[P_Q0+k-1][i][NC-2:0], 1'b0};
					end else begin
						cn_s[P_Q0+k][i] <= cn_s[P_Q0+k-1][i];
						cq_s[P_Q0+k][i] <= cq_s[P_Q0+k-1][i];
					end
				end
			end
			for (int k = P_QI + 1; k <= P_L; k++) mz_s[k] <= mz_s[k-1];
		end
	end

	// swirl and radial numerators, then divide the radial one by |d|
	always_ff @(posedge clk) begin
		if (en) begin
			qd_s[P_RP] <= rr_s[P_QE][26:0];
			for (int k = P_RP + 1; k <= P_L; k++) qd_s[k] <= qd_s[k-1];
			for (int i = 0; i < 3; i++) begin
				wc_s[i] <= 52'(w_q) * 52'(cg_s[P_QE][i]
					? -$signed({1'b0, cq_s[P_QE][i]}) : $signed({1'b0, cq_s[P_QE][i]}));
				rp_s[i] <= 35'(radial_q) * 35'(d_s[P_QE][i]);
				sw_s[P_RI][i] <= wc_s[i][51]
					? -$signed({1'b0, 32'((52'(-wc_s[i]) + (52'(1) << 19)) >> 20)})
					: $signed({1'b0, 32'((52'(wc_s[i]) + (52'(1) << 19)) >> 20)});
				rn_s[P_RI][i] <= (rp_s[i][34] ? RNW'(-rp_s[i]) << 8 : RNW'(rp_s[i]) << 8)
					+ RNW'(qd_s[P_RP] >> 1);
				rg_s[P_RI][i] <= rp_s[i][34];
				rq_s[P_RI][i] <= '0;
				for (int k = 0; k < NR; k++) begin
					sw_s[P_R0+k][i] <= sw_s[P_R0+k-1][i];
					rg_s[P_R0+k][i] <= rg_s[P_R0+k-1][i];
					if (rn_s[P_R0+k-1][i] >= (RNW'(qd_s[P_R0+k-1]) << (NR - 1 - k))) begin
						rn_s[P_R0+k][i] <= rn_s[P_R0+k-1][i]
							- (RNW'(qd_s[P_R0+k-1]) << (NR - 1 - k));
						rq_s[P_R0+k][i] <= {rq_s[P_R0+k-1][i][NR-2:0], 1'b1};
					end else begin
						rn_s[P_R0+k][i] <= rn_s[P_R0+k-1][i];
						rq_s[P_R0+k][i] <= {rq_s[P_R0+k-1][i][NR-2:0], 1'b0};
					end
				end
			end
		end
	end

	// ---------------- sum, saturate, output register with skid ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zero_axis) begin
				res_v[i] = 24'sh0;
			end else begin
				res_v[i] = sat24(34'(sw_s[P_L][i]) + 34'(axt_q[i])
					+ (mz_s[P_L] ? 34'sh0 : (rg_s[P_L][i]
						? -$signed({1'b0, 33'(rq_s[P_L][i])})
						: $signed({1'b0, 33'(rq_s[P_L][i])}))));
			end
		end
		if (zero_axis) begin
			res_st = STAT_ZERO_AXIS;
		end else if (mz_s[P_L]) begin
			res_st = STAT_ON_AXIS;
		end else begin
			res_st = STAT_OK;
		end
	end

	assign pipe_out = vld_s[P_L] & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (vel_valid && !vel_ready) begin
			if (pipe_out) skid_v_q <= 1'b1;
		end else begin
			vel_valid <= skid_v_q | pipe_out;
			skid_v_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vel_valid && !vel_ready) begin
			// hold the waiting word, park the next one
			if (pipe_out) begin
				skid_v_d_q <= res_v;
				skid_st_q  <= res_st;
			end
		end else if (skid_v_q) begin
			vel_x  <= skid_v_d_q[0];
			vel_y  <= skid_v_d_q[1];
			vel_z  <= skid_v_d_q[2];
			status <= skid_st_q;
		end else if (pipe_out) begin
			vel_x  <= res_v[0];
			vel_y  <= res_v[1];
			vel_z  <= res_v[2];
			status <= res_st;
		end
	end

endmodule
